// ===== sv/srt_pkg.sv =====
// Shared types and constants of the successor ring table.
// Depends on nothing; every other file of the block imports it.
package srt_pkg;

    localparam int KEY_W = 10;
    localparam int OP_W  = 4;

    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 4'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 4'd2;
    localparam logic [OP_W-1:0] OP_SEPARATE = 4'd3;
    localparam logic [OP_W-1:0] OP_MERGE    = 4'd4;
    localparam logic [OP_W-1:0] OP_SPLIT    = 4'd5;
    localparam logic [OP_W-1:0] OP_PRED     = 4'd6;
    localparam logic [OP_W-1:0] OP_SAME     = 4'd7;
    localparam logic [OP_W-1:0] OP_SIZE     = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic             swap_order;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] predecessor;
        logic [KEY_W-1:0] ring_size;
        logic             same_ring;
    } t_rsp;

    // One write port and one read port of the successor table.
    typedef struct packed {
        logic             we;
        logic [KEY_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [KEY_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_WALK_GO,
        ST_WALK,
        ST_POST,
        ST_WR1,
        ST_WR2
    } t_state;

endpackage

// ===== sv/srt_table.sv =====
// Successor table storage: one write port and one read port with registered data.
// Depends on srt_pkg for the key width and the port request type.
module srt_table #(
    parameter int DEPTH = 1024
) (
    input  logic                      i_clk,
    input  srt_pkg::t_mem_req         i_req,
    output logic [srt_pkg::KEY_W-1:0] o_rdata
);
    import srt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/successor_ring_table_core.sv =====
// Top level of the successor ring table: request sequencer around one table memory.
// Depends on srt_pkg and instantiates srt_table.
//
// Usage. A request is taken at a rising edge where start is high and busy is low;
// its fields arrive on i_req. Exactly one result per request appears on o_result
// for a single cycle, flagged by o_done; the receiver cannot hold it off, and busy
// falls in the same cycle that o_done rises, so the next request may follow at once.
// Add, unused opcodes and requests settled by the first two table reads finish after
// those reads; delete and separate of a key that is alone on its ring add one table
// write. Predecessor, same ring and ring size walk the ring after the reads, as do
// merges of keys that share a ring and splits that fail or find the second key already
// next; the remaining deletes, separates, merges and splits walk the ring and then
// write the table twice. The walk covers the first key's ring, or the second key's
// ring (after any role swap) for merge, split and same ring, and follows one successor
// link per read of the single table port. The clear opcode sweeps the table one entry
// a cycle over TABLE_DEPTH entries (capped at 1024). After reset the same sweep runs
// with busy high and gives no result; reset is synchronous and active low.
module successor_ring_table_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  srt_pkg::t_req i_req,
    output logic          o_done,
    output srt_pkg::t_rsp o_result
);
    import srt_pkg::*;

    // Keys are ten bits wide, so no more than 1024 entries can ever be addressed.
    localparam int MEM_DEPTH = (TABLE_DEPTH < (1 << KEY_W)) ? TABLE_DEPTH : (1 << KEY_W);
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [KEY_W:0]  DEPTH_LIM = (KEY_W + 1)'(MEM_DEPTH);
    localparam logic [AW-1:0]   CLR_LAST  = AW'(MEM_DEPTH - 1);

    // A key is usable when it is neither the null key nor beyond the table.
    function automatic logic key_ok(input logic [KEY_W-1:0] k);
        return (k != '0) && ({1'b0, k} < DEPTH_LIM);
    endfunction

    function automatic t_rsp mk_rsp(input logic ok, input logic [KEY_W-1:0] pr,
                                    input logic [KEY_W-1:0] rs, input logic sr);
        t_rsp r;
        r.ok          = ok;
        r.predecessor = pr;
        r.ring_size   = rs;
        r.same_ring   = sr;
        return r;
    endfunction

    t_state           r_state, n_state;
    logic [OP_W-1:0]  r_op, n_op;
    logic [KEY_W-1:0] r_a, n_a;          // first key, after any role swap
    logic [KEY_W-1:0] r_b, n_b;          // second key, after any role swap
    logic             r_va, n_va;
    logic             r_vb, n_vb;
    logic [KEY_W-1:0] r_sa, n_sa;        // successor of the first key, zero if absent
    logic [KEY_W-1:0] r_start, n_start;  // key where the ring walk begins and ends
    logic [KEY_W-1:0] r_cur, n_cur;
    logic [KEY_W-1:0] r_pred, n_pred;
    logic [KEY_W-1:0] r_count, n_count;
    logic             r_found, n_found;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_clr_reply, n_clr_reply;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    t_mem_req         w_mem;
    logic [KEY_W-1:0] w_rdata;
    logic [KEY_W-1:0] w_sb;
    logic [KEY_W-1:0] w_in_a;
    logic [KEY_W-1:0] w_in_b;
    logic             w_accept;
    logic             w_swap;
    logic             w_sa_zero;
    logic             w_sa_self;
    logic             w_sb_zero;
    logic             w_walk_end;
    logic             w_clr_last;

    srt_table #(
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Merge and split may exchange the roles of the two keys; nothing else does.
    assign w_swap = i_req.swap_order &&
                    ((i_req.opcode == OP_MERGE) || (i_req.opcode == OP_SPLIT));
    assign w_in_a = w_swap ? i_req.key_b : i_req.key_a;
    assign w_in_b = w_swap ? i_req.key_a : i_req.key_b;

    assign w_sb       = r_vb ? w_rdata : '0;
    assign w_sa_zero  = (r_sa == '0);
    assign w_sa_self  = (r_sa == r_a);
    assign w_sb_zero  = (w_sb == '0);
    // The walk closes when the link leads back to its starting key; a zero link
    // would mean a broken ring and also stops it.
    assign w_walk_end = (w_rdata == r_start) || (w_rdata == '0);
    assign w_clr_last = (r_clr_addr == CLR_LAST);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.opcode == OP_CLEAR) ? ST_CLEAR : ST_RDA;
                end
            end
            ST_RDA: begin
                n_state = ST_RDB;
            end
            ST_RDB: begin
                case (r_op) inside
                    OP_DELETE, OP_SEPARATE: begin
                        if (w_sa_zero) begin
                            n_state = ST_IDLE;
                        end else if (w_sa_self) begin
                            n_state = ST_WR2;
                        end else begin
                            n_state = ST_WALK_GO;
                        end
                    end
                    OP_PRED, OP_SIZE: begin
                        n_state = w_sa_zero ? ST_IDLE : ST_WALK_GO;
                    end
                    OP_MERGE, OP_SPLIT, OP_SAME: begin
                        n_state = (w_sa_zero || w_sb_zero) ? ST_IDLE : ST_WALK_GO;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_WALK_GO: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (w_walk_end) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                case (r_op) inside
                    OP_DELETE, OP_SEPARATE: begin
                        n_state = ST_WR1;
                    end
                    OP_MERGE: begin
                        n_state = r_found ? ST_IDLE : ST_WR1;
                    end
                    OP_SPLIT: begin
                        n_state = (!r_found || (r_sa == r_b)) ? ST_IDLE : ST_WR1;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_WR1: begin
                n_state = ST_WR2;
            end
            ST_WR2: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs: table port, working registers and the result.
    always_comb begin
        w_mem.we    = 1'b0;
        w_mem.waddr = r_a;
        w_mem.wdata = '0;
        w_mem.raddr = r_a;

        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_va        = r_va;
        n_vb        = r_vb;
        n_sa        = r_sa;
        n_start     = r_start;
        n_cur       = r_cur;
        n_pred      = r_pred;
        n_count     = r_count;
        n_found     = r_found;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_out_valid = 1'b0;
        n_out       = r_out;

        unique case (r_state)
            ST_CLEAR: begin
                w_mem.we    = 1'b1;
                w_mem.waddr = KEY_W'(r_clr_addr);
                w_mem.wdata = '0;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (w_clr_last) begin
                    n_clr_reply = 1'b0;
                    if (r_clr_reply) begin
                        n_out_valid = 1'b1;
                        n_out       = mk_rsp(1'b1, '0, '0, 1'b0);
                    end
                end
            end
            ST_IDLE: begin
                // The first key's successor is fetched as the request is taken.
                w_mem.raddr = w_in_a;
                if (w_accept) begin
                    n_op        = i_req.opcode;
                    n_a         = w_in_a;
                    n_b         = w_in_b;
                    n_va        = key_ok(w_in_a);
                    n_vb        = key_ok(w_in_b);
                    n_clr_addr  = '0;
                    n_clr_reply = 1'b1;
                end
            end
            ST_RDA: begin
                n_sa        = r_va ? w_rdata : '0;
                w_mem.raddr = r_b;
            end
            ST_RDB: begin
                n_start = ((r_op == OP_MERGE) || (r_op == OP_SPLIT) || (r_op == OP_SAME)) ?
                          r_b : r_a;
                case (r_op) inside
                    OP_ADD: begin
                        n_out_valid = 1'b1;
                        n_out       = mk_rsp(r_va && w_sa_zero, '0, '0, 1'b0);
                        if (r_va && w_sa_zero) begin
                            w_mem.we    = 1'b1;
                            w_mem.waddr = r_a;
                            w_mem.wdata = r_a;
                        end
                    end
                    OP_DELETE, OP_SEPARATE, OP_PRED, OP_SIZE: begin
                        if (w_sa_zero) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_rsp(1'b0, '0, '0, 1'b0);
                        end
                    end
                    OP_MERGE, OP_SPLIT: begin
                        if (w_sa_zero || w_sb_zero) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_rsp(1'b0, '0, '0, 1'b0);
                        end
                    end
                    OP_SAME: begin
                        // A present first key with an absent second key still succeeds.
                        if (w_sa_zero || w_sb_zero) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_rsp(!w_sa_zero, '0, '0, 1'b0);
                        end
                    end
                    default: begin
                        n_out_valid = 1'b1;
                        n_out       = mk_rsp(1'b0, '0, '0, 1'b0);
                    end
                endcase
            end
            ST_WALK_GO: begin
                w_mem.raddr = r_start;
                n_cur       = r_start;
                n_count     = KEY_W'(1);
                n_found     = 1'b0;
            end
            ST_WALK: begin
                // Every key of the ring passes through r_cur once; the last one
                // before the start is the start key's predecessor.
                n_found = r_found || (r_cur == r_a);
                if (w_walk_end) begin
                    n_pred = r_cur;
                end else begin
                    n_cur       = w_rdata;
                    w_mem.raddr = w_rdata;
                    n_count     = r_count + KEY_W'(1);
                end
            end
            ST_POST: begin
                case (r_op) inside
                    OP_PRED: begin
                        n_out_valid = 1'b1;
                        n_out       = mk_rsp(1'b1, r_pred, '0, 1'b0);
                    end
                    OP_SIZE: begin
                        n_out_valid = 1'b1;
                        n_out       = mk_rsp(1'b1, '0, r_count, 1'b0);
                    end
                    OP_SAME: begin
                        n_out_valid = 1'b1;
                        n_out       = mk_rsp(1'b1, '0, '0, r_found);
                    end
                    OP_MERGE: begin
                        if (r_found) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_rsp(1'b0, '0, '0, 1'b0);
                        end
                    end
                    OP_SPLIT: begin
                        if (!r_found || (r_sa == r_b)) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_rsp(r_found, '0, '0, 1'b0);
                        end
                    end
                    default: begin
                        n_out_valid = 1'b0;
                    end
                endcase
            end
            ST_WR1: begin
                w_mem.we = 1'b1;
                if ((r_op == OP_DELETE) || (r_op == OP_SEPARATE)) begin
                    // Close the ring over the key that leaves it.
                    w_mem.waddr = r_pred;
                    w_mem.wdata = r_sa;
                end else begin
                    w_mem.waddr = r_a;
                    w_mem.wdata = r_b;
                end
            end
            ST_WR2: begin
                w_mem.we    = 1'b1;
                n_out_valid = 1'b1;
                n_out       = mk_rsp(1'b1, '0, '0, 1'b0);
                case (r_op) inside
                    OP_DELETE: begin
                        w_mem.waddr = r_a;
                        w_mem.wdata = '0;
                    end
                    OP_SEPARATE: begin
                        w_mem.waddr = r_a;
                        w_mem.wdata = r_a;
                    end
                    default: begin
                        w_mem.waddr = r_pred;
                        w_mem.wdata = r_sa;
                    end
                endcase
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_va    <= n_va;
        r_vb    <= n_vb;
        r_sa    <= n_sa;
        r_start <= n_start;
        r_cur   <= n_cur;
        r_pred  <= n_pred;
        r_count <= n_count;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign o_done   = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTH
    // A result only ever comes out of work that was under way.
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state != ST_IDLE))
        else $error("result strobe without a request in progress");

    // A failed request never reports query data.
    a_fail_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.ok) |->
        ((o_result.predecessor == '0) && (o_result.ring_size == '0) && !o_result.same_ring))
        else $error("failed result carries query data");

    // The table is never written while the block waits for a request.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_mem.we)
        else $error("table written while idle");

    // The ring walk only visits present keys, never the null key.
    a_walk_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cur != '0))
        else $error("ring walk reached the null key");
`endif

endmodule
